>>> rtl/core/assert_macros.svh
// Assertion macros shared by the viewport aspect fit RTL.
// Every macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst_n is low.
`define VVAF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while rst_n is low.
`define VVAF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/vvaf_pkg.sv
// Package for the viewport aspect fit block: widths, mode and operation codes,
// the queued job record and the offset helper. It depends on nothing else.
package vvaf_pkg;

  localparam int unsigned DIM_BITS = 14;
  localparam int unsigned SAR_BITS = 16;
  localparam int unsigned OUT_BITS = 31;

  localparam int unsigned SQ_W   = 2 * DIM_BITS;
  localparam int unsigned DIV_W  = DIM_BITS + SAR_BITS;
  localparam int unsigned PROD_W = 2 * DIM_BITS + SAR_BITS;
  localparam int unsigned Q_W    = OUT_BITS;

  localparam logic [OUT_BITS-1:0] SIDE_MAX = {OUT_BITS{1'b1}};

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    MODE_STRETCH = 2'd0,
    MODE_FIT     = 2'd1,
    MODE_FILL    = 2'd2,
    MODE_NATIVE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    OP_STRETCH,
    OP_NATIVE,
    OP_SCALE_W,
    OP_SCALE_H,
    OP_ERROR
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic                sat;
    logic [DIM_BITS-1:0] sw;
    logic [DIM_BITS-1:0] sh;
    logic [DIM_BITS-1:0] vw;
    logic [DIM_BITS-1:0] vh;
    logic [DIV_W-1:0]    rem;
    logic [DIV_W-1:0]    div;
    logic [Q_W-1:0]      lo;
  } job_t;

  // Half of (surface - side), rounded toward zero.
  function automatic logic signed [OUT_BITS-1:0] half_gap(
    input logic [DIM_BITS-1:0] surf,
    input logic [OUT_BITS-1:0] side
  );
    logic signed [OUT_BITS+1:0] diff;
    logic signed [OUT_BITS+1:0] biased;
    diff   = $signed((OUT_BITS+2)'(surf)) - $signed((OUT_BITS+2)'(side));
    biased = diff + $signed({{(OUT_BITS+1){1'b0}}, diff[OUT_BITS+1]});
    return $signed(biased[OUT_BITS:1]);
  endfunction

endpackage

>>> rtl/core/vvaf_if.sv
// Channel interfaces of the viewport aspect fit block: request, result and
// mode write. Widths come from vvaf_pkg.
interface vvaf_req_if;
  logic                          valid;
  logic                          ready;
  logic [vvaf_pkg::DIM_BITS-1:0] surface_width;
  logic [vvaf_pkg::DIM_BITS-1:0] surface_height;
  logic [vvaf_pkg::DIM_BITS-1:0] video_width;
  logic [vvaf_pkg::DIM_BITS-1:0] video_height;
  logic [vvaf_pkg::SAR_BITS-1:0] sample_aspect_w;
  logic [vvaf_pkg::SAR_BITS-1:0] sample_aspect_h;

  modport source (
    output valid, surface_width, surface_height, video_width, video_height,
    output sample_aspect_w, sample_aspect_h,
    input  ready
  );
  modport sink (
    input  valid, surface_width, surface_height, video_width, video_height,
    input  sample_aspect_w, sample_aspect_h,
    output ready
  );
endinterface

interface vvaf_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vvaf_pkg::OUT_BITS-1:0] view_x;
  logic signed [vvaf_pkg::OUT_BITS-1:0] view_y;
  logic        [vvaf_pkg::OUT_BITS-1:0] view_width;
  logic        [vvaf_pkg::OUT_BITS-1:0] view_height;
  logic                                 divide_error;

  modport source (
    output valid, view_x, view_y, view_width, view_height, divide_error,
    input  ready
  );
  modport sink (
    input  valid, view_x, view_y, view_width, view_height, divide_error,
    output ready
  );
endinterface

interface vvaf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] display_mode;

  modport source (output valid, display_mode, input ready);
  modport sink (input valid, display_mode, output ready);
endinterface

>>> rtl/core/vvaf_front.sv
// Front end: holds the display mode, accepts requests, forms the cross
// products and classifies each job. Uses vvaf_pkg, vvaf_if and assert_macros.svh.
`include "assert_macros.svh"

module vvaf_front (
  input  logic            clk,
  input  logic            rst_n,
  vvaf_cfg_if.sink        cfg,
  vvaf_req_if.sink        req,
  output logic            job_valid,
  output vvaf_pkg::job_t  job,
  input  logic            job_ready
);

  localparam int unsigned DW  = vvaf_pkg::DIM_BITS;
  localparam int unsigned SW  = vvaf_pkg::SAR_BITS;
  localparam int unsigned SQW = vvaf_pkg::SQ_W;
  localparam int unsigned VW  = vvaf_pkg::DIV_W;
  localparam int unsigned PW  = vvaf_pkg::PROD_W;
  localparam int unsigned QW  = vvaf_pkg::Q_W;

  vvaf_pkg::mode_t mode_r;
  logic            adv;

  logic            v1_r, v2_r, v3_r, v4_r;
  vvaf_pkg::mode_t mode1_r, mode2_r, mode3_r;
  logic [DW-1:0]   sw1_r, sh1_r, vw1_r, vh1_r;
  logic [DW-1:0]   sw2_r, sh2_r, vw2_r, vh2_r;
  logic [DW-1:0]   sw3_r, sh3_r, vw3_r, vh3_r;
  logic [SW-1:0]   sah1_r;
  logic [SQW-1:0]  pa1_r;
  logic [VW-1:0]   ph1_r, pw1_r, ph2_r, pw2_r, ph3_r, pw3_r;
  logic [PW-1:0]   a2_r, b2_r, a3_r, b3_r;
  logic            lt3_r, gt3_r;

  logic            scale_h;
  logic [PW-1:0]   num;
  logic [PW-1:0]   num_hi;
  logic [VW-1:0]   div;
  vvaf_pkg::job_t  job_nxt;
  vvaf_pkg::job_t  job_r;

  assign adv       = !v4_r || job_ready;
  assign req.ready = adv;
  assign cfg.ready = 1'b1;
  assign job_valid = v4_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= vvaf_pkg::MODE_STRETCH;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        mode_r <= vvaf_pkg::mode_t'(cfg.display_mode);
      end
      if (adv) begin
        v1_r <= req.valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= mode_r;
      sw1_r   <= req.surface_width;
      sh1_r   <= req.surface_height;
      vw1_r   <= req.video_width;
      vh1_r   <= req.video_height;
      sah1_r  <= req.sample_aspect_h;
      pa1_r   <= SQW'(req.surface_width) * SQW'(req.video_height);
      ph1_r   <= VW'(req.video_width) * VW'(req.sample_aspect_w);
      pw1_r   <= VW'(req.video_height) * VW'(req.sample_aspect_h);

      mode2_r <= mode1_r;
      sw2_r   <= sw1_r;
      sh2_r   <= sh1_r;
      vw2_r   <= vw1_r;
      vh2_r   <= vh1_r;
      ph2_r   <= ph1_r;
      pw2_r   <= pw1_r;
      a2_r    <= PW'(pa1_r) * PW'(sah1_r);
      b2_r    <= PW'(ph1_r) * PW'(sh1_r);

      mode3_r <= mode2_r;
      sw3_r   <= sw2_r;
      sh3_r   <= sh2_r;
      vw3_r   <= vw2_r;
      vh3_r   <= vh2_r;
      ph3_r   <= ph2_r;
      pw3_r   <= pw2_r;
      a3_r    <= a2_r;
      b3_r    <= b2_r;
      lt3_r   <= a2_r < b2_r;
      gt3_r   <= a2_r > b2_r;

      job_r   <= job_nxt;
    end
  end

  always_comb begin
    case (mode3_r)
      vvaf_pkg::MODE_FIT:  scale_h = lt3_r;
      vvaf_pkg::MODE_FILL: scale_h = gt3_r;
      default:             scale_h = 1'b0;
    endcase
    num    = scale_h ? a3_r : b3_r;
    div    = scale_h ? ph3_r : pw3_r;
    num_hi = num >> QW;

    job_nxt.sw  = sw3_r;
    job_nxt.sh  = sh3_r;
    job_nxt.vw  = vw3_r;
    job_nxt.vh  = vh3_r;
    job_nxt.div = div;
    job_nxt.sat = num_hi >= PW'(div);
    job_nxt.rem = VW'(num_hi);
    job_nxt.lo  = QW'(num);
    case (mode3_r)
      vvaf_pkg::MODE_STRETCH: job_nxt.op = vvaf_pkg::OP_STRETCH;
      vvaf_pkg::MODE_NATIVE:  job_nxt.op = vvaf_pkg::OP_NATIVE;
      default: begin
        if (div == '0) begin
          job_nxt.op = vvaf_pkg::OP_ERROR;
        end else if (scale_h) begin
          job_nxt.op = vvaf_pkg::OP_SCALE_H;
        end else begin
          job_nxt.op = vvaf_pkg::OP_SCALE_W;
        end
      end
    endcase
  end

  `VVAF_ASSERT_IMP(a_scale_div_nonzero, v4_r && (job_r.op == vvaf_pkg::OP_SCALE_H || job_r.op == vvaf_pkg::OP_SCALE_W), job_r.div != '0, "Scaling job queued with a zero divisor.")

endmodule

>>> rtl/core/vvaf_fifo.sv
// Short job queue between the front end and the divider back end.
// Uses vvaf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module vvaf_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  vvaf_pkg::job_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output vvaf_pkg::job_t pop_data,
  input  logic           pop_ready
);

  localparam int unsigned AW = vvaf_pkg::FIFO_AW;
  localparam int unsigned CW = vvaf_pkg::FIFO_AW + 1;

  vvaf_pkg::job_t mem_r [vvaf_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;
  logic           push;
  logic           pop;

  assign push_ready = cnt_r != CW'(vvaf_pkg::FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `VVAF_ASSERT_NXT(a_fifo_count, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "Queue count did not follow a lone push.")

endmodule

>>> rtl/core/vvaf_back.sv
// Back end: pipelined restoring divider, one quotient bit per stage, then side
// selection, saturation, offsets and the result register. Uses vvaf_pkg, vvaf_if
// and assert_macros.svh.
`include "assert_macros.svh"

module vvaf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  vvaf_pkg::job_t job,
  output logic           job_ready,
  vvaf_rsp_if.source     rsp
);

  localparam int unsigned DW = vvaf_pkg::DIM_BITS;
  localparam int unsigned VW = vvaf_pkg::DIV_W;
  localparam int unsigned QW = vvaf_pkg::Q_W;
  localparam int unsigned OW = vvaf_pkg::OUT_BITS;

  typedef struct packed {
    vvaf_pkg::job_t job;
    logic [QW-1:0]  quo;
  } dstage_t;

  typedef struct packed {
    logic [OW-1:0] w;
    logic [OW-1:0] h;
    logic [DW-1:0] sw;
    logic [DW-1:0] sh;
    logic          off_x;
    logic          off_y;
    logic          err;
  } fin_t;

  logic            adv;
  logic [QW-1:0]   dvv_r;
  dstage_t         dv_r     [QW];
  dstage_t         dv_src   [QW];
  dstage_t         dv_nxt   [QW];
  logic [VW:0]     dv_trial [QW];
  logic            dv_ge    [QW];

  dstage_t         last;
  logic [OW-1:0]   side;
  fin_t            fin_nxt;
  fin_t            fin_r;
  logic            fin_v_r;

  logic                 out_v_r;
  logic signed [OW-1:0] out_x_r;
  logic signed [OW-1:0] out_y_r;
  logic [OW-1:0]        out_w_r;
  logic [OW-1:0]        out_h_r;
  logic                 out_err_r;

  assign adv              = !out_v_r || rsp.ready;
  assign job_ready        = adv;
  assign rsp.valid        = out_v_r;
  assign rsp.view_x       = out_x_r;
  assign rsp.view_y       = out_y_r;
  assign rsp.view_width   = out_w_r;
  assign rsp.view_height  = out_h_r;
  assign rsp.divide_error = out_err_r;

  always_comb begin
    dv_src[0].job = job;
    dv_src[0].quo = '0;
    for (int i = 1; i < QW; i++) begin
      dv_src[i] = dv_r[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      dv_trial[i]       = {dv_src[i].job.rem, dv_src[i].job.lo[QW-1]};
      dv_ge[i]          = dv_trial[i] >= {1'b0, dv_src[i].job.div};
      dv_nxt[i]         = dv_src[i];
      dv_nxt[i].job.rem = dv_ge[i] ? VW'(dv_trial[i] - {1'b0, dv_src[i].job.div})
                                   : VW'(dv_trial[i]);
      dv_nxt[i].job.lo  = dv_src[i].job.lo << 1;
      dv_nxt[i].quo     = {dv_src[i].quo[QW-2:0], dv_ge[i]};
    end
  end

  always_comb begin
    last    = dv_r[QW-1];
    side    = last.job.sat ? vvaf_pkg::SIDE_MAX : last.quo;
    fin_nxt = '0;
    fin_nxt.sw = last.job.sw;
    fin_nxt.sh = last.job.sh;
    case (last.job.op)
      vvaf_pkg::OP_STRETCH: begin
        fin_nxt.w = OW'(last.job.sw);
        fin_nxt.h = OW'(last.job.sh);
      end
      vvaf_pkg::OP_NATIVE: begin
        fin_nxt.w     = OW'(last.job.vw);
        fin_nxt.h     = OW'(last.job.vh);
        fin_nxt.off_x = 1'b1;
        fin_nxt.off_y = 1'b1;
      end
      vvaf_pkg::OP_SCALE_H: begin
        fin_nxt.w     = OW'(last.job.sw);
        fin_nxt.h     = side;
        fin_nxt.off_y = 1'b1;
      end
      vvaf_pkg::OP_SCALE_W: begin
        fin_nxt.w     = side;
        fin_nxt.h     = OW'(last.job.sh);
        fin_nxt.off_x = 1'b1;
      end
      vvaf_pkg::OP_ERROR: begin
        fin_nxt.err = 1'b1;
      end
      default: begin
        fin_nxt.err = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r   <= '0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      dvv_r   <= {dvv_r[QW-2:0], job_valid};
      fin_v_r <= dvv_r[QW-1];
      out_v_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r      <= dv_nxt;
      fin_r     <= fin_nxt;
      out_x_r   <= fin_r.off_x ? vvaf_pkg::half_gap(fin_r.sw, fin_r.w) : '0;
      out_y_r   <= fin_r.off_y ? vvaf_pkg::half_gap(fin_r.sh, fin_r.h) : '0;
      out_w_r   <= fin_r.w;
      out_h_r   <= fin_r.h;
      out_err_r <= fin_r.err;
    end
  end

  `VVAF_ASSERT_NXT(a_out_hold, out_v_r && !rsp.ready, out_v_r && $stable(out_x_r) && $stable(out_y_r) && $stable(out_w_r) && $stable(out_h_r) && $stable(out_err_r), "Result changed while stalled.")
  `VVAF_ASSERT_IMP(a_err_zero, out_v_r && out_err_r, out_x_r == '0 && out_y_r == '0 && out_w_r == '0 && out_h_r == '0, "Divide error with a nonzero rectangle.")

endmodule

>>> rtl/core/video_viewport_aspect_fit.sv
// Viewport aspect fit top level: front end, job queue and divider back end.
// Path from an accepted request to its valid result: four front stages, the job queue,
// 31 divider stages and two finishing stages.
// Throughput is one transaction per cycle while out_rsp does not stall, set by the one-bit-per-stage divider.
// Synchronous reset on rst_n low empties pipeline and queue and sets stretch mode.
// Uses vvaf_pkg, vvaf_if, vvaf_front, vvaf_fifo and vvaf_back.
module video_viewport_aspect_fit (
  input  logic       clk,
  input  logic       rst_n,
  vvaf_cfg_if.sink   cfg_wr,
  vvaf_req_if.sink   in_req,
  vvaf_rsp_if.source out_rsp
);

  logic           push_valid;
  logic           push_ready;
  vvaf_pkg::job_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  vvaf_pkg::job_t pop_data;

  vvaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_wr),
    .req       (in_req),
    .job_valid (push_valid),
    .job       (push_data),
    .job_ready (push_ready)
  );

  vvaf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  vvaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (pop_valid),
    .job       (pop_data),
    .job_ready (pop_ready),
    .rsp       (out_rsp)
  );

endmodule
